/* rtl/csw_pkg.sv */
package csw_pkg;

  // Field widths of the channels and registers
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned RIDX_W    = 4;
  localparam int unsigned AIDX_W    = 5;
  localparam int unsigned VAL_W     = 24;
  localparam int unsigned STEPS_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;
  localparam int unsigned COEF_W    = 24;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned FRAC      = 20;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RUN   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIAL_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIAL_COEF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_COEF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIAL_COEF   = 3'd5;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic [RIDX_W-1:0]         ring_index;
    logic [AIDX_W-1:0]         angle_index;
    logic signed [VAL_W-1:0]   sample_value;
    logic [STEPS_W-1:0]        step_count;
  } req_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] pressure_value;
    logic                    index_error;
  } rsp_item_t;

endpackage

/* rtl/csw_req_if.sv */
interface csw_req_if import csw_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/csw_rsp_if.sv */
interface csw_rsp_if import csw_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/csw_ram.sv */
module csw_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cylindrical_wave_stencil_unit.sv */
// Channel   Dir  Payload                                              Transfer
// in_i      in   req_type ring_index angle_index sample_value step_count valid & ready
// out_o     out  pressure_value index_error                           valid & ready
// cfg_*     in   cfg_index_i cfg_data_i                               cfg_we_i high
//
// A load goes through S_DONE; a read through S_READ and S_DONE; a run
// of zero steps through S_STEP and S_DONE. Each interior cell of a step
// takes eight reads through the single store port, then six products in
// turn on a shared multiplier, then one write.
// After reset, and on a clear request, a pass writes zero to every store entry,
// 3 << (ring, angle and axial address bits) of them (24576 at the defaults);
// no request is taken during the pass. A result waits in the output register
// while the next request is taken.
module cylindrical_wave_stencil_unit import csw_pkg::*; #(
  parameter int unsigned RINGS_MAX    = 16,
  parameter int unsigned ANGLES_MAX   = 32,
  parameter int unsigned AXIAL_MAX    = 16,
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  csw_req_if.sink              in_i,
  csw_rsp_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned RW    = $clog2(RINGS_MAX);
  localparam int unsigned AW    = (ANGLES_MAX > 1) ? $clog2(ANGLES_MAX) : 1;
  localparam int unsigned ZW    = $clog2(AXIAL_MAX);
  localparam int unsigned ADW   = 2 + RW + AW + ZW;
  localparam int unsigned DEPTH = 3 << (RW + AW + ZW);
  localparam int unsigned CW    = 22;
  localparam int unsigned MA    = COEF_W + 1;
  localparam int unsigned MB    = SW + 3;
  localparam int unsigned PW    = MA + MB;
  localparam int unsigned ACW   = PW + 2;
  localparam int unsigned NW    = SW + 8;
  localparam int unsigned XW    = ((SW > VAL_W) ? SW : VAL_W) + 1;

  localparam logic [ADW-1:0]        CLR_LAST = ADW'(DEPTH - 1);
  localparam logic signed [ACW-1:0] RND_HALF = ACW'(1) << (FRAC - 1);
  localparam logic [CNT_W-1:0]      RMAX     = CNT_W'(RINGS_MAX);
  localparam logic [CNT_W-1:0]      TMAX     = CNT_W'(ANGLES_MAX);
  localparam logic [CNT_W-1:0]      ZMAX     = CNT_W'(AXIAL_MAX);
  localparam logic signed [XW-1:0]  SMAX_X   = XW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [XW-1:0]  SMIN_X   = -SMAX_X - XW'(1);
  localparam logic signed [XW-1:0]  VMAX_X   = XW'((64'sd1 <<< (VAL_W - 1)) - 64'sd1);
  localparam logic signed [XW-1:0]  VMIN_X   = -VMAX_X - XW'(1);
  localparam logic signed [NW-1:0]  SMAX_N   = NW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [NW-1:0]  SMIN_N   = -SMAX_N - NW'(1);

  // Controller states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_MAC   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // Operand slots, in read order
  localparam logic [2:0] OP_U   = 3'd0;
  localparam logic [2:0] OP_RP  = 3'd1;
  localparam logic [2:0] OP_RM  = 3'd2;
  localparam logic [2:0] OP_TP  = 3'd3;
  localparam logic [2:0] OP_TM  = 3'd4;
  localparam logic [2:0] OP_ZP  = 3'd5;
  localparam logic [2:0] OP_ZM  = 3'd6;
  localparam logic [2:0] OP_P   = 3'd7;

  // Ring coefficient table, worked out at elaboration
  logic [CW-1:0] pc_tbl [RINGS_MAX];
  logic [CW-1:0] mc_tbl [RINGS_MAX];
  logic [CW-1:0] sc_tbl [RINGS_MAX];

  for (genvar g = 0; g < RINGS_MAX; g++) begin : g_ring_tbl
    localparam int unsigned GI  = (g == 0) ? 1 : g;
    localparam int unsigned PCV = (((2 * GI + 1) << FRAC) + GI) / (2 * GI);
    localparam int unsigned MCV = (((2 * GI - 1) << FRAC) + GI) / (2 * GI);
    localparam int unsigned SCV = ((1 << (FRAC + 1)) + GI * GI) / (2 * GI * GI);
    assign pc_tbl[g] = CW'(PCV);
    assign mc_tbl[g] = CW'(MCV);
    assign sc_tbl[g] = CW'(SCV);
  end

  function automatic logic [ADW-1:0] mk_addr(input logic [1:0] b, input logic [RW-1:0] r,
                                             input logic [AW-1:0] a, input logic [ZW-1:0] z);
    mk_addr = {b, r, a, z};
  endfunction

  function automatic logic signed [MB-1:0] sx(input logic [SW-1:0] v);
    sx = {{(MB - SW){v[SW-1]}}, v};
  endfunction

  // Registers
  logic [2:0]              state_q, state_d;
  logic [4:0]              ring_cnt_q;
  logic [5:0]              angle_cnt_q;
  logic [4:0]              axial_cnt_q;
  logic [COEF_W-1:0]       rcoef_q, acoef_q, zcoef_q;
  logic [1:0]              cb_q, cb_d;
  logic [ADW-1:0]          clr_q, clr_d;
  logic                    clr_cmd_q, clr_cmd_d;
  logic [STEPS_W-1:0]      steps_q, steps_d;
  logic [RW-1:0]           i_q, i_d;
  logic [AW-1:0]           j_q, j_d;
  logic [ZW-1:0]           k_q, k_d;
  logic [2:0]              ph_q, ph_d;
  logic [2:0]              mst_q, mst_d;
  logic                    cap_v_q;
  logic [2:0]              cap_sel_q;
  logic [SW-1:0]           opnd_q [8];
  logic signed [ACW-1:0]   acc_q, acc_d;
  logic signed [MB-1:0]    rad_q, ang_q;
  logic signed [VAL_W-1:0] pend_pv_q, pend_pv_d;
  logic                    pend_err_q, pend_err_d;
  logic                    out_valid_q;
  rsp_item_t               out_data_q;

  // Store port
  logic           ram_we;
  logic [ADW-1:0] ram_waddr, ram_raddr;
  logic [SW-1:0]  ram_wdata, ram_rdata;

  csw_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_field_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Effective counts
  logic [CNT_W-1:0] nr, nt, nz, rc8, tc8, zc8;
  always_comb begin
    rc8 = CNT_W'(ring_cnt_q);
    tc8 = CNT_W'(angle_cnt_q);
    zc8 = CNT_W'(axial_cnt_q);
    nr  = (rc8 > RMAX) ? RMAX : rc8;
    nt  = (tc8 > TMAX) ? TMAX : ((tc8 == '0) ? CNT_W'(1) : tc8);
    nz  = (zc8 > ZMAX) ? ZMAX : zc8;
  end

  // Bank roles
  logic [1:0] nb, pb;
  assign nb = (cb_q == 2'd2) ? 2'd0 : cb_q + 2'd1;
  assign pb = (cb_q == 2'd0) ? 2'd2 : cb_q - 2'd1;

  // Request decode
  req_item_t        req;
  logic [CNT_W-1:0] ri8, ai8;
  logic             idx_bad, in_xfer;
  logic signed [XW-1:0] sv_x, ld_x;
  assign req     = in_i.data;
  assign ri8     = CNT_W'(req.ring_index);
  assign ai8     = CNT_W'(req.angle_index);
  assign idx_bad = (ri8 >= nr) || (ai8 >= nt);
  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer = in_i.valid && in_i.ready;
  assign sv_x = {{(XW - VAL_W){req.sample_value[VAL_W-1]}}, req.sample_value};
  assign ld_x = (sv_x > SMAX_X) ? SMAX_X : ((sv_x < SMIN_X) ? SMIN_X : sv_x);

  // Read-back clamp to the result width
  logic signed [XW-1:0] rd_x, rd_c;
  assign rd_x = {{(XW - SW){ram_rdata[SW-1]}}, ram_rdata};
  assign rd_c = (rd_x > VMAX_X) ? VMAX_X : ((rd_x < VMIN_X) ? VMIN_X : rd_x);

  // Neighbour indexes
  logic [CNT_W-1:0] i8, j8, k8, jp8, jm8;
  logic             interior;
  assign i8  = CNT_W'(i_q);
  assign j8  = CNT_W'(j_q);
  assign k8  = CNT_W'(k_q);
  assign jp8 = (j8 + CNT_W'(1) >= nt) ? '0 : j8 + CNT_W'(1);
  assign jm8 = (j8 == '0) ? nt - CNT_W'(1) : j8 - CNT_W'(1);
  assign interior = (nr >= CNT_W'(3)) && (nz >= CNT_W'(3));

  // Shared multiplier and stencil terms
  logic signed [MB-1:0]  u_s, d_r1, d_r2, d_t, d_z;
  logic signed [NW-1:0]  u_n, p_n, lap_n, nx_n, nx_c;
  logic signed [MA-1:0]  m_a;
  logic signed [MB-1:0]  m_b;
  logic signed [PW-1:0]  prod;
  logic signed [ACW-1:0] prod_x, acc_r;

  assign u_s  = sx(opnd_q[OP_U]);
  assign d_r1 = sx(opnd_q[OP_RP]) - u_s;
  assign d_r2 = u_s - sx(opnd_q[OP_RM]);
  assign d_t  = sx(opnd_q[OP_TP]) - (u_s <<< 1) + sx(opnd_q[OP_TM]);
  assign d_z  = sx(opnd_q[OP_ZP]) - (u_s <<< 1) + sx(opnd_q[OP_ZM]);

  always_comb begin
    m_a = '0;
    m_b = '0;
    case (mst_q)
      3'd0: begin m_a = MA'(pc_tbl[i_q]); m_b = d_r1; end
      3'd1: begin m_a = MA'(mc_tbl[i_q]); m_b = d_r2; end
      3'd2: begin m_a = MA'(sc_tbl[i_q]); m_b = d_t; end
      3'd3: begin m_a = MA'(rcoef_q); m_b = rad_q; end
      3'd4: begin m_a = MA'(acoef_q); m_b = ang_q; end
      3'd5: begin m_a = MA'(zcoef_q); m_b = d_z; end
      default: begin m_a = '0; m_b = '0; end
    endcase
  end

  assign prod   = m_a * m_b;
  assign prod_x = {{(ACW - PW){prod[PW-1]}}, prod};
  // Round half up: add half an LSB, then floor by the arithmetic shift
  assign acc_r  = (acc_q + RND_HALF) >>> FRAC;
  assign lap_n  = acc_r[NW-1:0];
  assign u_n    = {{(NW - SW){opnd_q[OP_U][SW-1]}}, opnd_q[OP_U]};
  assign p_n    = {{(NW - SW){opnd_q[OP_P][SW-1]}}, opnd_q[OP_P]};
  assign nx_n   = (u_n <<< 1) - p_n + lap_n;
  assign nx_c   = (nx_n > SMAX_N) ? SMAX_N : ((nx_n < SMIN_N) ? SMIN_N : nx_n);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cb_d       = cb_q;
    clr_d      = clr_q;
    clr_cmd_d  = clr_cmd_q;
    steps_d    = steps_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    ph_d       = ph_q;
    mst_d      = mst_q;
    acc_d      = acc_q;
    pend_pv_d  = pend_pv_q;
    pend_err_d = pend_err_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == CLR_LAST) begin
          clr_d   = '0;
          cb_d    = 2'd0;
          state_d = clr_cmd_q ? S_DONE : S_IDLE;
        end else begin
          clr_d = clr_q + ADW'(1);
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          pend_pv_d  = '0;
          pend_err_d = 1'b0;
          ram_raddr  = mk_addr(cb_q, ri8[RW-1:0], ai8[AW-1:0], '0);
          case (req.req_type)
            REQ_LOAD: begin
              pend_err_d = idx_bad;
              ram_we     = !idx_bad;
              ram_waddr  = mk_addr(cb_q, ri8[RW-1:0], ai8[AW-1:0], '0);
              ram_wdata  = ld_x[SW-1:0];
              state_d    = S_DONE;
            end
            REQ_READ: begin
              pend_err_d = idx_bad;
              state_d    = idx_bad ? S_DONE : S_READ;
            end
            REQ_RUN: begin
              steps_d = req.step_count;
              state_d = S_STEP;
            end
            default: begin
              clr_cmd_d = 1'b1;
              clr_d     = '0;
              state_d   = S_CLEAR;
            end
          endcase
        end
      end

      S_READ: begin
        pend_pv_d = rd_c[VAL_W-1:0];
        state_d   = S_DONE;
      end

      S_STEP: begin
        if (steps_q == '0) begin
          state_d = S_DONE;
        end else if (!interior) begin
          cb_d    = nb;
          steps_d = steps_q - STEPS_W'(1);
        end else begin
          i_d     = RW'(1);
          j_d     = '0;
          k_d     = ZW'(1);
          ph_d    = OP_U;
          state_d = S_RD;
        end
      end

      // Eight reads per cell: centre, ring, angle and axial neighbours, previous
      S_RD: begin
        case (ph_q)
          OP_U:    ram_raddr = mk_addr(cb_q, i_q, j_q, k_q);
          OP_RP:   ram_raddr = mk_addr(cb_q, i_q + RW'(1), j_q, k_q);
          OP_RM:   ram_raddr = mk_addr(cb_q, i_q - RW'(1), j_q, k_q);
          OP_TP:   ram_raddr = mk_addr(cb_q, i_q, jp8[AW-1:0], k_q);
          OP_TM:   ram_raddr = mk_addr(cb_q, i_q, jm8[AW-1:0], k_q);
          OP_ZP:   ram_raddr = mk_addr(cb_q, i_q, j_q, k_q + ZW'(1));
          OP_ZM:   ram_raddr = mk_addr(cb_q, i_q, j_q, k_q - ZW'(1));
          default: ram_raddr = mk_addr(pb, i_q, j_q, k_q);
        endcase
        ph_d = ph_q + 3'd1;
        if (ph_q == OP_P) begin
          mst_d   = '0;
          state_d = S_MAC;
        end
      end

      // Products in turn, then the write of the next bank
      S_MAC: begin
        mst_d = mst_q + 3'd1;
        case (mst_q)
          3'd0: acc_d = prod_x;
          3'd1: acc_d = acc_q - prod_x;
          3'd2: acc_d = prod_x;
          3'd3: acc_d = prod_x;
          3'd4: acc_d = acc_q + prod_x;
          3'd5: acc_d = acc_q + prod_x;
          default: begin
            ram_we    = 1'b1;
            ram_waddr = mk_addr(nb, i_q, j_q, k_q);
            ram_wdata = nx_c[SW-1:0];
            ph_d      = OP_U;
            state_d   = S_RD;
            if (k8 + CNT_W'(2) < nz) begin
              k_d = k_q + ZW'(1);
            end else begin
              k_d = ZW'(1);
              if (j8 + CNT_W'(1) < nt) begin
                j_d = j_q + AW'(1);
              end else begin
                j_d = '0;
                if (i8 + CNT_W'(2) < nr) begin
                  i_d = i_q + RW'(1);
                end else begin
                  cb_d    = nb;
                  steps_d = steps_q - STEPS_W'(1);
                  state_d = S_STEP;
                end
              end
            end
          end
        endcase
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          clr_cmd_d = 1'b0;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cb_q        <= 2'd0;
      clr_q       <= '0;
      clr_cmd_q   <= 1'b0;
      steps_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      ph_q        <= '0;
      mst_q       <= '0;
      cap_v_q     <= 1'b0;
      cap_sel_q   <= '0;
      out_valid_q <= 1'b0;
      ring_cnt_q  <= 5'd16;
      angle_cnt_q <= 6'd32;
      axial_cnt_q <= 5'd16;
      rcoef_q     <= '0;
      acoef_q     <= '0;
      zcoef_q     <= '0;
    end else begin
      state_q   <= state_d;
      cb_q      <= cb_d;
      clr_q     <= clr_d;
      clr_cmd_q <= clr_cmd_d;
      steps_q   <= steps_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      ph_q      <= ph_d;
      mst_q     <= mst_d;
      cap_v_q   <= (state_q == S_RD);
      cap_sel_q <= ph_q;
      if (state_q == S_DONE && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_RING_COUNT:   ring_cnt_q  <= cfg_data_i[4:0];
          CFG_ANGLE_COUNT:  angle_cnt_q <= cfg_data_i[5:0];
          CFG_AXIAL_COUNT:  axial_cnt_q <= cfg_data_i[4:0];
          CFG_RADIAL_COEF:  rcoef_q     <= cfg_data_i;
          CFG_ANGULAR_COEF: acoef_q     <= cfg_data_i;
          CFG_AXIAL_COEF:   zcoef_q     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    pend_pv_q  <= pend_pv_d;
    pend_err_q <= pend_err_d;
    if (cap_v_q) begin
      opnd_q[cap_sel_q] <= ram_rdata;
    end
    if (state_q == S_MAC && mst_q == 3'd2) begin
      rad_q <= acc_r[MB-1:0];
    end
    if (state_q == S_MAC && mst_q == 3'd3) begin
      ang_q <= acc_r[MB-1:0];
    end
    if (state_q == S_DONE && (!out_valid_q || out_o.ready)) begin
      out_data_q.pressure_value <= pend_pv_q;
      out_data_q.index_error    <= pend_err_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
